FILE: rtl/fbla_pkg.sv
`default_nettype none

package fbla_pkg;

    // sizes
    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int BLK_W          = 12;
    localparam int PSIZE_W        = 13;
    localparam int KIND_W         = 1;
    localparam int STATUS_W       = 2;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;

    localparam logic [PSIZE_W-1:0] PSIZE_RESET = 13'd4096;
    localparam logic [PSIZE_W-1:0] PSIZE_MIN   = 13'd2;

    // register indexes
    localparam logic REG_PARTITION_SIZE = 1'b0;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 1'b0;
    localparam logic [KIND_W-1:0] KIND_RETURN = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OUT_RANGE = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BLK_W-1:0]  return_block;
    } fbla_in_t;

    typedef struct packed {
        logic [BLK_W-1:0]    given_block;
        logic [STATUS_W-1:0] status;
        logic                list_now_empty;
    } fbla_out_t;

endpackage

`default_nettype wire

FILE: rtl/fbla_ram.sv
`default_nettype none

module fbla_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fifo_free_block_list_allocator.sv
// a request is accepted in the idle state and its result is registered from the execute state;
// new requests wait until the last one leaves the execute state (forward link read-modify-write);
// a stalled result waits in the hold state and blocks new requests until the output is free
// reset: rst_n clears control, then a rebuild pass writes all MAX_BLOCKS (capped at 4096)
// link entries one per cycle while no request is accepted; a partition_size write
// starts the same rebuild pass
`default_nettype none

module fifo_free_block_list_allocator
    import fbla_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // request channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire fbla_in_t              in_req,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output fbla_out_t                  out_req,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int DEPTH = (MAX_BLOCKS < 4096) ? MAX_BLOCKS : 4096;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PSIZE_W-1:0] CAP       = PSIZE_W'(DEPTH);
    localparam logic [AW-1:0]      LAST_IDX  = AW'(DEPTH - 1);

    localparam logic [1:0] S_INIT = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [AW-1:0]      sweep_reg, sweep_next;
    logic [PSIZE_W-1:0] psize_reg, psize_next;
    logic [BLK_W-1:0]   head_reg, head_next;
    logic [BLK_W-1:0]   tail_reg, tail_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [BLK_W-1:0]   blk_reg, blk_next;
    logic               bad_reg, bad_next;
    logic               out_valid_reg, out_valid_next;
    fbla_out_t          out_reg, out_next;
    fbla_out_t          pend_reg, pend_next;

    logic               cfg_wr;
    logic               accept;
    logic               out_free;
    logic               in_bad;
    logic [PSIZE_W-1:0] p_eff;
    logic [PSIZE_W-1:0] sweep_b;
    logic [PSIZE_W-1:0] sweep_b1;
    fbla_out_t          res;

    logic               fwd_we, fwd_re;
    logic [AW-1:0]      fwd_waddr, fwd_raddr;
    logic [BLK_W-1:0]   fwd_wdata, fwd_rdata;
    logic               bk_we;
    logic [AW-1:0]      bk_waddr;
    logic [BLK_W-1:0]   bk_wdata;

    // link memories
    fbla_ram #(.WIDTH(BLK_W), .DEPTH(DEPTH)) u_fwd_ram (
        .clk   (clk),
        .we    (fwd_we),
        .waddr (fwd_waddr),
        .wdata (fwd_wdata),
        .re    (fwd_re),
        .raddr (fwd_raddr),
        .rdata (fwd_rdata)
    );

    fbla_ram #(.WIDTH(BLK_W), .DEPTH(DEPTH)) u_back_ram (
        .clk   (clk),
        .we    (bk_we),
        .waddr (bk_waddr),
        .wdata (bk_wdata),
        .re    (1'b0),
        .raddr ('0),
        .rdata ()
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PARTITION_SIZE);
    assign prdata = (paddr[2] == REG_PARTITION_SIZE) ?
                    APB_DATA_W'(psize_reg) : '0;

    // effective partition size
    always_comb
    begin
        p_eff = psize_reg;
        if (psize_reg < PSIZE_MIN)
        begin
            p_eff = PSIZE_MIN;
        end
        else if (psize_reg > CAP)
        begin
            p_eff = CAP;
        end
    end

    // handshake
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_req   = out_reg;

    assign in_bad   = (in_req.return_block == '0) ||
                      ({1'b0, in_req.return_block} >= p_eff);
    assign sweep_b  = PSIZE_W'(sweep_reg);
    assign sweep_b1 = sweep_b + PSIZE_W'(1);

    // result of the request in the execute cycle
    always_comb
    begin
        res = '0;
        res.status = STATUS_OK;
        if (kind_reg == KIND_RETURN)
        begin
            if (bad_reg)
            begin
                res.status = STATUS_OUT_RANGE;
            end
        end
        else if (head_reg == '0)
        begin
            res.status = STATUS_FULL;
        end
        else
        begin
            res.given_block    = head_reg;
            res.list_now_empty = (fwd_rdata == '0);
        end
    end

    // control and memory access
    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        psize_next     = psize_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        kind_next      = kind_reg;
        blk_next       = blk_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        pend_next      = pend_reg;

        fwd_we    = 1'b0;
        fwd_waddr = '0;
        fwd_wdata = '0;
        fwd_re    = 1'b0;
        fwd_raddr = head_reg[AW-1:0];
        bk_we     = 1'b0;
        bk_waddr  = '0;
        bk_wdata  = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            // rebuild the chain one entry per cycle
            S_INIT:
            begin
                fwd_we    = 1'b1;
                fwd_waddr = sweep_reg;
                fwd_wdata = ((sweep_b != '0) && (sweep_b1 < p_eff)) ?
                            sweep_b1[BLK_W-1:0] : '0;
                bk_we     = 1'b1;
                bk_waddr  = sweep_reg;
                bk_wdata  = ((sweep_b != '0) && (sweep_b < p_eff)) ?
                            BLK_W'(sweep_b - PSIZE_W'(1)) : '0;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == LAST_IDX)
                begin
                    sweep_next = '0;
                    head_next  = BLK_W'(1);
                    tail_next  = BLK_W'(p_eff - PSIZE_W'(1));
                    state_next = S_IDLE;
                end
            end

            // accept: allocate reads the head link, return does its first writes
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = in_req.kind;
                    blk_next   = in_req.return_block;
                    bad_next   = in_bad;
                    state_next = S_EXEC;
                    if (in_req.kind == KIND_ALLOC)
                    begin
                        fwd_re = 1'b1;
                    end
                    else if (!in_bad)
                    begin
                        bk_we    = 1'b1;
                        bk_waddr = in_req.return_block[AW-1:0];
                        bk_wdata = tail_reg;
                        if (tail_reg != '0)
                        begin
                            fwd_we    = 1'b1;
                            fwd_waddr = tail_reg[AW-1:0];
                            fwd_wdata = in_req.return_block;
                        end
                        else
                        begin
                            head_next = in_req.return_block;
                        end
                        tail_next = in_req.return_block;
                    end
                end
            end

            // finish: pop the head or terminate the new tail
            S_EXEC:
            begin
                if (kind_reg == KIND_RETURN)
                begin
                    if (!bad_reg)
                    begin
                        fwd_we    = 1'b1;
                        fwd_waddr = blk_reg[AW-1:0];
                        fwd_wdata = '0;
                    end
                end
                else if (head_reg != '0)
                begin
                    head_next = fwd_rdata;
                    if (fwd_rdata == '0)
                    begin
                        tail_next = '0;
                    end
                    else
                    begin
                        bk_we    = 1'b1;
                        bk_waddr = fwd_rdata[AW-1:0];
                        bk_wdata = '0;
                    end
                end
                if (out_free)
                begin
                    out_next       = res;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    pend_next  = res;
                    state_next = S_HOLD;
                end
            end

            // result parked until the output register frees up
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_INIT;
                sweep_next = '0;
            end
        endcase

        // a size write restarts the rebuild
        if (cfg_wr)
        begin
            psize_next = pwdata[PSIZE_W-1:0];
            sweep_next = '0;
            state_next = S_INIT;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sweep_reg     <= '0;
            psize_reg     <= PSIZE_RESET;
            head_reg      <= BLK_W'(1);
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            psize_reg     <= psize_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        blk_reg  <= blk_next;
        bad_reg  <= bad_next;
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

endmodule

`default_nettype wire
